### rtl/htw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the hashed timer wheel.
// No dependencies; used by htw_div and hashed_timer_wheel_core.
package htw_pkg;

	localparam int TIMEOUT_W   = 24;
	localparam int TICK_W      = 16;
	localparam int SLOTS_CFG_W = 9;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int DIVIDEND_W  = 25;
	localparam int DIVISOR_W   = 16;
	localparam int DIV_CNT_W   = 5;

	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_RESTART = 2'd1;
	localparam logic [1:0] KIND_CANCEL  = 2'd2;
	localparam logic [1:0] KIND_TICK    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_MS      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'd1;

	localparam logic [TICK_W-1:0]      TICK_MS_RESET = 16'd100;
	localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET   = 9'd256;

	typedef struct packed {
		logic [1:0]           kind;
		logic [5:0]           timer_id;
		logic [TIMEOUT_W-1:0] delay_ms;
	} in_t;

	typedef struct packed {
		logic [5:0] expired_timer;
		logic       last_expired;
	} out_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVISOR_W-1:0]  remainder;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_U_RD,
		ST_U_ID,
		ST_U_P,
		ST_U_N,
		ST_MOD_GO,
		ST_MOD_WAIT,
		ST_TDIV_GO,
		ST_TDIV_WAIT,
		ST_SLOT,
		ST_I_RD,
		ST_I_HEAD,
		ST_I_PREV,
		ST_T_RD,
		ST_T_HEAD,
		ST_T_WALK
	} state_t;

endpackage
`default_nettype wire

### rtl/htw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/htw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// Depends on htw_pkg for operand widths and the request/response structs.
module htw_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire htw_pkg::div_req_t req,
	output htw_pkg::div_rsp_t      rsp
);

	logic [htw_pkg::DIVIDEND_W-1:0] quo_q;
	logic [htw_pkg::DIVISOR_W-1:0]  rem_q;
	logic [htw_pkg::DIVISOR_W-1:0]  dvs_q;
	logic [htw_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [htw_pkg::DIVISOR_W:0]    trial;
	logic [htw_pkg::DIVISOR_W:0]    diff;
	logic                           ge;

	always_comb begin
		trial = {rem_q, quo_q[htw_pkg::DIVIDEND_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= htw_pkg::DIV_CNT_W'(htw_pkg::DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == htw_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[htw_pkg::DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[htw_pkg::DIVISOR_W-1:0] : trial[htw_pkg::DIVISOR_W-1:0];
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

### rtl/hashed_timer_wheel_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the hashed timer wheel: sequencer over the slot head RAM and timer RAM.
// Depends on htw_pkg, htw_ram and htw_div.
//
//  channel | signals                      | direction
//  --------+------------------------------+----------
//  in      | in_valid, in_stall, in_data  | command in
//  out     | out_valid, out_stall, out_data | expiry out
//  cfg     | cfg_we, cfg_index, cfg_wdata | register write
//
// After reset the slot head RAM is swept to empty; in_stall stays high meanwhile.
// Cancel of a linked timer unlinks it (unlink walks the neighbors); otherwise cancel does nothing.
// Start/restart run a 25-step divide of the timeout, then the insert; the timer is
// unlinked first when linked, and the current slot is reduced by a further divide when
// it is not below slots_in_use after slots_in_use shrank.
// A tick (after the same slot reduction) emits one expiry per timer in the current slot; out_stall holds the walk.
// One item is worked on at a time; the output register holds a result under out_stall.
module hashed_timer_wheel_core #(
	parameter int SLOTS  = 256,
	parameter int TIMERS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire htw_pkg::in_t                    in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output htw_pkg::out_t                        out_data,
	input  wire logic                            cfg_we,
	input  wire logic [htw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [htw_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int TID_W  = $clog2(TIMERS);
	localparam int LINK_W = TID_W + 1;
	localparam int TE_W   = 2 * LINK_W + SLOT_W;
	localparam int NX_LSB = LINK_W + SLOT_W;
	localparam int PV_LSB = SLOT_W;
	localparam logic [LINK_W-1:0] NIL = {1'b1, {TID_W{1'b0}}};

	htw_pkg::state_t state_q, state_d;

	logic [htw_pkg::TICK_W-1:0]      tick_q;
	logic [htw_pkg::SLOTS_CFG_W-1:0] slots_q;
	logic [SLOT_W-1:0]               cur_q;
	logic [SLOT_W-1:0]               curm_q;
	logic [SLOT_W-1:0]               off_q;
	logic [SLOT_W-1:0]               dst_q;
	logic [SLOT_W-1:0]               clr_q;
	logic [1:0]                      kind_q;
	logic [TID_W-1:0]                tid_q;
	logic [htw_pkg::TIMEOUT_W-1:0]   timeout_q;
	logic [LINK_W-1:0]               up_q, un_q, h_q, node_q;
	logic [SLOT_W-1:0]               us_q;
	logic [TIMERS-1:0]               linked_q;
	logic                            out_valid_q;
	htw_pkg::out_t                   out_q;

	logic                 hd_we;
	logic [SLOT_W-1:0]    hd_waddr, hd_raddr;
	logic [LINK_W-1:0]    hd_wdata, hd_rdata;
	logic                 tm_we;
	logic [TID_W-1:0]     tm_waddr, tm_raddr;
	logic [TE_W-1:0]      tm_wdata, tm_rdata;

	htw_pkg::div_req_t div_req;
	htw_pkg::div_rsp_t div_rsp;

	logic                  in_acc, id_ok, out_free, out_load, last_node;
	logic [TID_W-1:0]      in_tid;
	logic [CNT_W-1:0]      n_used;
	logic [31:0]           n_ext;
	logic                  cur_small;
	logic [LINK_W-1:0]     rd_next, rd_prev;
	logic [SLOT_W-1:0]     rd_slot;
	logic [htw_pkg::DIVIDEND_W-1:0] num, offr;
	logic [htw_pkg::TICK_W-1:0]     tick_eff;
	logic [SLOT_W-1:0]     off_sat;
	logic [SLOT_W:0]       dst_sum;
	logic [SLOT_W-1:0]     dst_wrap;
	logic [SLOT_W:0]       cur_inc;
	logic [SLOT_W-1:0]     cur_next;

	// effective slot count and operand preparation
	always_comb begin
		if (slots_q == '0) begin
			n_ext = 32'd1;
		end else if (32'(slots_q) > 32'(SLOTS)) begin
			n_ext = 32'(SLOTS);
		end else begin
			n_ext = 32'(slots_q);
		end
		n_used    = n_ext[CNT_W-1:0];
		cur_small = 32'(cur_q) < n_ext;
		tick_eff  = (tick_q == '0) ? htw_pkg::TICK_W'(1) : tick_q;
		num       = {1'b0, timeout_q} + htw_pkg::DIVIDEND_W'(tick_eff)
		            - htw_pkg::DIVIDEND_W'(1);
		offr      = (div_rsp.quotient == '0) ? '0
		            : div_rsp.quotient - htw_pkg::DIVIDEND_W'(1);
		off_sat   = (32'(offr) > n_ext - 32'd1) ? SLOT_W'(n_ext - 32'd1) : SLOT_W'(offr);
		dst_sum   = {1'b0, curm_q} + {1'b0, off_q};
		dst_wrap  = (32'(dst_sum) >= n_ext) ? SLOT_W'(32'(dst_sum) - n_ext) : dst_sum[SLOT_W-1:0];
		cur_inc   = {1'b0, curm_q} + (SLOT_W+1)'(1);
		cur_next  = (32'(cur_inc) == n_ext) ? '0 : cur_inc[SLOT_W-1:0];
		rd_next   = tm_rdata[NX_LSB +: LINK_W];
		rd_prev   = tm_rdata[PV_LSB +: LINK_W];
		rd_slot   = tm_rdata[SLOT_W-1:0];
		in_tid    = in_data.timer_id[TID_W-1:0];
		id_ok     = 32'(in_data.timer_id) < 32'(TIMERS);
		in_acc    = in_valid && !in_stall;
		out_free  = !out_valid_q || !out_stall;
		last_node = rd_next[TID_W];
	end

	assign in_stall  = (state_q != htw_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			htw_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (in_data.kind == htw_pkg::KIND_TICK) begin
						state_d = htw_pkg::ST_MOD_GO;
					end else if (id_ok) begin
						if (linked_q[in_tid]) begin
							state_d = htw_pkg::ST_U_RD;
						end else if (in_data.kind != htw_pkg::KIND_CANCEL) begin
							state_d = htw_pkg::ST_MOD_GO;
						end
					end
				end
			end
			htw_pkg::ST_CLEAR: begin
				if (clr_q == SLOT_W'(SLOTS - 1)) state_d = htw_pkg::ST_IDLE;
			end
			htw_pkg::ST_U_RD: state_d = htw_pkg::ST_U_ID;
			htw_pkg::ST_U_ID: state_d = htw_pkg::ST_U_P;
			htw_pkg::ST_U_P:  state_d = htw_pkg::ST_U_N;
			htw_pkg::ST_U_N: begin
				state_d = (kind_q == htw_pkg::KIND_CANCEL) ? htw_pkg::ST_IDLE
				          : htw_pkg::ST_MOD_GO;
			end
			htw_pkg::ST_MOD_GO: begin
				if (!cur_small) begin
					state_d = htw_pkg::ST_MOD_WAIT;
				end else if (kind_q == htw_pkg::KIND_TICK) begin
					state_d = htw_pkg::ST_T_RD;
				end else begin
					state_d = htw_pkg::ST_TDIV_GO;
				end
			end
			htw_pkg::ST_MOD_WAIT: begin
				if (div_rsp.done) begin
					state_d = (kind_q == htw_pkg::KIND_TICK) ? htw_pkg::ST_T_RD
					          : htw_pkg::ST_TDIV_GO;
				end
			end
			htw_pkg::ST_TDIV_GO: state_d = htw_pkg::ST_TDIV_WAIT;
			htw_pkg::ST_TDIV_WAIT: begin
				if (div_rsp.done) state_d = htw_pkg::ST_SLOT;
			end
			htw_pkg::ST_SLOT:   state_d = htw_pkg::ST_I_RD;
			htw_pkg::ST_I_RD:   state_d = htw_pkg::ST_I_HEAD;
			htw_pkg::ST_I_HEAD: state_d = htw_pkg::ST_I_PREV;
			htw_pkg::ST_I_PREV: state_d = htw_pkg::ST_IDLE;
			htw_pkg::ST_T_RD:   state_d = htw_pkg::ST_T_HEAD;
			htw_pkg::ST_T_HEAD: begin
				state_d = hd_rdata[TID_W] ? htw_pkg::ST_IDLE : htw_pkg::ST_T_WALK;
			end
			htw_pkg::ST_T_WALK: begin
				if (out_free && last_node) state_d = htw_pkg::ST_IDLE;
			end
			default: state_d = htw_pkg::ST_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		hd_we    = 1'b0;
		hd_waddr = curm_q;
		hd_wdata = NIL;
		hd_raddr = curm_q;
		tm_we    = 1'b0;
		tm_waddr = tid_q;
		tm_wdata = tm_rdata;
		tm_raddr = tid_q;
		out_load = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = htw_pkg::DIVIDEND_W'(cur_q);
		div_req.divisor  = htw_pkg::DIVISOR_W'(n_used);
		unique case (state_q)
			htw_pkg::ST_CLEAR: begin
				hd_we    = 1'b1;
				hd_waddr = clr_q;
			end
			htw_pkg::ST_U_ID: begin
				if (!rd_prev[TID_W]) begin
					tm_raddr = rd_prev[TID_W-1:0];
				end else begin
					hd_we    = 1'b1;
					hd_waddr = rd_slot;
					hd_wdata = rd_next;
				end
			end
			htw_pkg::ST_U_P: begin
				tm_raddr = un_q[TID_W-1:0];
				if (!up_q[TID_W]) begin
					tm_we    = 1'b1;
					tm_waddr = up_q[TID_W-1:0];
					tm_wdata[NX_LSB +: LINK_W] = un_q;
				end
			end
			htw_pkg::ST_U_N: begin
				if (!un_q[TID_W]) begin
					tm_we    = 1'b1;
					tm_waddr = un_q[TID_W-1:0];
					tm_wdata[PV_LSB +: LINK_W] = up_q;
				end
			end
			htw_pkg::ST_MOD_GO: begin
				div_req.start = !cur_small;
			end
			htw_pkg::ST_TDIV_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = num;
				div_req.divisor  = tick_eff;
			end
			htw_pkg::ST_I_RD: begin
				hd_raddr = dst_q;
			end
			htw_pkg::ST_I_HEAD: begin
				hd_we    = 1'b1;
				hd_waddr = dst_q;
				hd_wdata = {1'b0, tid_q};
				tm_we    = 1'b1;
				tm_waddr = tid_q;
				tm_wdata = {hd_rdata, NIL, dst_q};
				tm_raddr = hd_rdata[TID_W-1:0];
			end
			htw_pkg::ST_I_PREV: begin
				if (!h_q[TID_W]) begin
					tm_we    = 1'b1;
					tm_waddr = h_q[TID_W-1:0];
					tm_wdata[PV_LSB +: LINK_W] = {1'b0, tid_q};
				end
			end
			htw_pkg::ST_T_HEAD: begin
				hd_we    = 1'b1;
				tm_raddr = hd_rdata[TID_W-1:0];
			end
			htw_pkg::ST_T_WALK: begin
				tm_raddr = node_q[TID_W-1:0];
				if (out_free) begin
					out_load = 1'b1;
					if (!last_node) tm_raddr = rd_next[TID_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= htw_pkg::ST_CLEAR;
			clr_q       <= '0;
			tick_q      <= htw_pkg::TICK_MS_RESET;
			slots_q     <= htw_pkg::SLOTS_RESET;
			cur_q       <= '0;
			linked_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == htw_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				unique case (cfg_index)
					htw_pkg::REG_TICK_MS:      tick_q  <= cfg_wdata;
					htw_pkg::REG_SLOTS_IN_USE: slots_q <= cfg_wdata[htw_pkg::SLOTS_CFG_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == htw_pkg::ST_U_N) linked_q[tid_q] <= 1'b0;
			if (state_q == htw_pkg::ST_I_HEAD) linked_q[tid_q] <= 1'b1;
			if (out_load) linked_q[node_q[TID_W-1:0]] <= 1'b0;
			// advance the wheel once the current slot is drained
			if ((state_q == htw_pkg::ST_T_HEAD && hd_rdata[TID_W])
			    || (state_q == htw_pkg::ST_T_WALK && out_free && last_node)) begin
				cur_q <= cur_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q    <= in_data.kind;
			tid_q     <= in_tid;
			timeout_q <= in_data.delay_ms;
		end
		if (state_q == htw_pkg::ST_U_ID) begin
			up_q <= rd_prev;
			un_q <= rd_next;
			us_q <= rd_slot;
		end
		if (state_q == htw_pkg::ST_MOD_GO && cur_small) curm_q <= cur_q;
		if (state_q == htw_pkg::ST_MOD_WAIT && div_rsp.done) begin
			curm_q <= div_rsp.remainder[SLOT_W-1:0];
		end
		if (state_q == htw_pkg::ST_TDIV_WAIT && div_rsp.done) off_q <= off_sat;
		if (state_q == htw_pkg::ST_SLOT) dst_q <= dst_wrap;
		if (state_q == htw_pkg::ST_I_HEAD) h_q <= hd_rdata;
		if (state_q == htw_pkg::ST_T_HEAD) node_q <= hd_rdata;
		if (state_q == htw_pkg::ST_T_WALK && out_free && !last_node) node_q <= rd_next;
		if (out_load) begin
			out_q.expired_timer <= 6'(node_q[TID_W-1:0]);
			out_q.last_expired  <= last_node;
		end
	end

	htw_ram #(
		.WIDTH (LINK_W),
		.DEPTH (SLOTS)
	) u_head_ram (
		.clk   (clk),
		.we    (hd_we),
		.waddr (hd_waddr),
		.wdata (hd_wdata),
		.raddr (hd_raddr),
		.rdata (hd_rdata)
	);

	htw_ram #(
		.WIDTH (TE_W),
		.DEPTH (TIMERS)
	) u_timer_ram (
		.clk   (clk),
		.we    (tm_we),
		.waddr (tm_waddr),
		.wdata (tm_wdata),
		.raddr (tm_raddr),
		.rdata (tm_rdata)
	);

	htw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("expiry loaded over a held transfer");

	a_walk_linked: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> linked_q[node_q[TID_W-1:0]])
		else $error("expired timer was not linked");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_insert_unlinked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htw_pkg::ST_I_HEAD) |-> !linked_q[tid_q])
		else $error("insert of a timer that is still linked");

	a_unlink_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htw_pkg::ST_U_N) |-> (32'(us_q) < 32'(SLOTS)))
		else $error("unlinked timer had a slot outside the wheel");
`endif

endmodule
`default_nettype wire
